// ===== hw/rtl/scmi_pkg.sv =====
// Shared types, command keys and reply codes of the sensor command interpreter.
package scmi_pkg;

  localparam logic [7:0] KEY_NULL         = 8'h00;
  localparam logic [7:0] KEY_GET_LED      = 8'h03;
  localparam logic [7:0] KEY_SET_LED      = 8'h04;
  localparam logic [7:0] KEY_GET_CONFIG   = 8'h07;
  localparam logic [7:0] KEY_SET_CONFIG   = 8'h08;
  localparam logic [7:0] KEY_GET_EXPOSURE = 8'h09;
  localparam logic [7:0] KEY_SET_EXPOSURE = 8'h0A;
  localparam logic [7:0] KEY_CAPTURE      = 8'h0B;

  localparam logic [7:0] ST_OK       = 8'h00;
  localparam logic [7:0] ST_ERR      = 8'h01;
  localparam logic [7:0] ST_INVALID  = 8'h02;
  localparam logic [7:0] LED_ERR_FILL = 8'hAB;

  localparam logic [7:0] GAIN_1X  = 8'h01;
  localparam logic [7:0] GAIN_CODE_A = 8'h25;
  localparam logic [7:0] GAIN_CODE_B = 8'h04;
  localparam logic [7:0] GAIN_CODE_C = 8'h05;
  localparam logic [7:0] ROWS_BAD_MASK = 8'hE0;
  localparam logic [7:0] ROWS_ALL = 8'h1F;
  localparam logic [15:0] EXPOSURE_RESET = 16'd50;

  // What the back end has to send for one accepted word.
  typedef enum logic [3:0] {
    JOB_OK         = 4'd0,
    JOB_OK_CAPTURE = 4'd1,
    JOB_OK_PROGRAM = 4'd2,
    JOB_ERR        = 4'd3,
    JOB_ERR_LED    = 4'd4,
    JOB_INVALID    = 4'd5,
    JOB_LED_STATE  = 4'd6,
    JOB_CONFIG     = 4'd7,
    JOB_EXPOSURE   = 4'd8
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [1:0]  led0;
    logic [1:0]  led1;
    logic [15:0] exposure;
  } job_t;

  typedef struct packed {
    logic [7:0]  reply_byte;
    logic        reply_last;
    logic        program_strobe;
    logic [27:0] program_word;
    logic        capture_start;
    logic [1:0]  led0_state;
    logic [1:0]  led1_state;
    logic [15:0] exposure_out;
  } result_t;

  // Two-bit array gain field for a gain byte.
  function automatic logic [1:0] gain_bits(input logic [7:0] gain);
    logic [1:0] g;
    g = 2'b00;
    if (gain == GAIN_CODE_A) g = 2'b10;
    else if (gain == GAIN_CODE_B) g = 2'b01;
    else if (gain == GAIN_CODE_C) g = 2'b11;
    return g;
  endfunction

endpackage

// ===== hw/rtl/scmi_front.sv =====
// Front end: parses received words, holds the board state, queues reply jobs.
module scmi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output logic               job_push,
  output scmi_pkg::job_t     job
);

  localparam logic [3:0] CMD_GET_LED      = 4'h3;
  localparam logic [3:0] CMD_SET_LED      = 4'h4;
  localparam logic [3:0] CMD_SET_CONFIG   = 4'h8;
  localparam logic [3:0] CMD_SET_EXPOSURE = 4'hA;

  logic [1:0]  parse_phase, parse_phase_next;
  logic [3:0]  pending_command, pending_command_next;
  logic [7:0]  held_payload_a, held_payload_a_next;
  logic [7:0]  held_payload_b, held_payload_b_next;
  logic [1:0]  led0, led0_next;
  logic [1:0]  led1, led1_next;
  logic [7:0]  stored_binning, stored_binning_next;
  logic [7:0]  stored_gain, stored_gain_next;
  logic [7:0]  stored_rows, stored_rows_next;
  logic [15:0] exposure_count, exposure_count_next;
  logic        has_job;
  scmi_pkg::job_kind_t kind;
  logic [7:0]  ja, jb, jc;
  logic        cfg_ok;

  always_comb begin
    parse_phase_next     = parse_phase;
    pending_command_next = pending_command;
    held_payload_a_next  = held_payload_a;
    held_payload_b_next  = held_payload_b;
    led0_next            = led0;
    led1_next            = led1;
    stored_binning_next  = stored_binning;
    stored_gain_next     = stored_gain;
    stored_rows_next     = stored_rows;
    exposure_count_next  = exposure_count;
    has_job = 1'b0;
    kind    = scmi_pkg::JOB_OK;
    ja      = '0;
    jb      = '0;
    jc      = '0;
    cfg_ok  = 1'b0;

    if (parse_phase == 2'd0) begin
      unique case (rx_byte) inside
        scmi_pkg::KEY_NULL: begin
        end
        scmi_pkg::KEY_GET_LED: begin
          pending_command_next = CMD_GET_LED;
          parse_phase_next     = 2'd1;
        end
        scmi_pkg::KEY_SET_LED: begin
          pending_command_next = CMD_SET_LED;
          parse_phase_next     = 2'd1;
        end
        scmi_pkg::KEY_SET_CONFIG: begin
          pending_command_next = CMD_SET_CONFIG;
          parse_phase_next     = 2'd1;
        end
        scmi_pkg::KEY_SET_EXPOSURE: begin
          pending_command_next = CMD_SET_EXPOSURE;
          parse_phase_next     = 2'd1;
        end
        scmi_pkg::KEY_GET_CONFIG: begin
          has_job = 1'b1;
          kind    = scmi_pkg::JOB_CONFIG;
          ja      = stored_binning;
          jb      = stored_gain;
          jc      = stored_rows;
        end
        scmi_pkg::KEY_GET_EXPOSURE: begin
          has_job = 1'b1;
          kind    = scmi_pkg::JOB_EXPOSURE;
          ja      = exposure_count[15:8];
          jb      = exposure_count[7:0];
        end
        scmi_pkg::KEY_CAPTURE: begin
          has_job = 1'b1;
          kind    = scmi_pkg::JOB_OK_CAPTURE;
        end
        default: begin
          has_job = 1'b1;
          kind    = scmi_pkg::JOB_INVALID;
        end
      endcase
    end else if (pending_command == CMD_GET_LED && parse_phase == 2'd1) begin
      parse_phase_next = 2'd0;
      has_job = 1'b1;
      if (rx_byte > 8'd1) begin
        kind = scmi_pkg::JOB_ERR_LED;
      end else begin
        kind = scmi_pkg::JOB_LED_STATE;
        ja   = {6'd0, rx_byte[0] ? led1 : led0};
      end
    end else if ((pending_command == CMD_SET_LED || pending_command == CMD_SET_EXPOSURE ||
                  pending_command == CMD_SET_CONFIG) && parse_phase == 2'd1) begin
      held_payload_a_next = rx_byte;
      parse_phase_next    = 2'd2;
    end else if (pending_command == CMD_SET_LED && parse_phase == 2'd2) begin
      parse_phase_next = 2'd0;
      has_job = 1'b1;
      if (held_payload_a > 8'd1 || rx_byte > 8'd2) begin
        kind = scmi_pkg::JOB_ERR;
      end else begin
        kind = scmi_pkg::JOB_OK;
        if (held_payload_a[0]) led1_next = rx_byte[1:0];
        else led0_next = rx_byte[1:0];
      end
    end else if (pending_command == CMD_SET_EXPOSURE && parse_phase == 2'd2) begin
      parse_phase_next    = 2'd0;
      exposure_count_next = {held_payload_a, rx_byte};
      has_job = 1'b1;
      kind    = scmi_pkg::JOB_OK;
    end else if (pending_command == CMD_SET_CONFIG && parse_phase == 2'd2) begin
      held_payload_b_next = rx_byte;
      parse_phase_next    = 2'd3;
    end else if (pending_command == CMD_SET_CONFIG && parse_phase == 2'd3) begin
      parse_phase_next    = 2'd0;
      // Store all three bytes, valid or not.
      stored_binning_next = held_payload_a;
      stored_gain_next    = held_payload_b;
      stored_rows_next    = rx_byte;
      cfg_ok = (held_payload_a == 8'd0 || held_payload_a == 8'd1) &&
               (held_payload_b == scmi_pkg::GAIN_1X ||
                held_payload_b == scmi_pkg::GAIN_CODE_A ||
                held_payload_b == scmi_pkg::GAIN_CODE_B ||
                held_payload_b == scmi_pkg::GAIN_CODE_C) &&
               ((rx_byte & scmi_pkg::ROWS_BAD_MASK) == 8'd0);
      has_job = 1'b1;
      kind    = cfg_ok ? scmi_pkg::JOB_OK_PROGRAM : scmi_pkg::JOB_ERR;
      ja      = held_payload_a;
      jb      = held_payload_b;
      jc      = rx_byte;
    end else begin
      // Phase does not fit the pending command: drop back to idle.
      parse_phase_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= 2'd0;
      pending_command <= 4'd0;
      led0            <= 2'd0;
      led1            <= 2'd0;
      stored_binning  <= 8'd0;
      stored_gain     <= scmi_pkg::GAIN_1X;
      stored_rows     <= scmi_pkg::ROWS_ALL;
      exposure_count  <= scmi_pkg::EXPOSURE_RESET;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      pending_command <= pending_command_next;
      led0            <= led0_next;
      led1            <= led1_next;
      stored_binning  <= stored_binning_next;
      stored_gain     <= stored_gain_next;
      stored_rows     <= stored_rows_next;
      exposure_count  <= exposure_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_payload_a <= held_payload_a_next;
      held_payload_b <= held_payload_b_next;
    end
  end

  assign job_push     = accept && has_job;
  assign job.kind     = kind;
  assign job.a        = ja;
  assign job.b        = jb;
  assign job.c        = jc;
  assign job.led0     = led0_next;
  assign job.led1     = led1_next;
  assign job.exposure = exposure_count_next;

endmodule

// ===== hw/rtl/scmi_queue.sv =====
// Job queue between the parser front end and the reply back end.
module scmi_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scmi_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output scmi_pkg::job_t pop_job,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scmi_pkg::job_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

endmodule

// ===== hw/rtl/scmi_back.sv =====
// Back end: expands each queued job into reply words behind an output register.
module scmi_back (
  input  logic              clk,
  input  logic              rst,
  input  scmi_pkg::job_t    job,
  input  logic              job_empty,
  output logic              job_pop,
  output scmi_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);

  logic [1:0]        idx;
  logic [1:0]        last_idx;
  logic [7:0]        status;
  scmi_pkg::result_t cur;
  logic              out_valid;
  logic              load;

  always_comb begin
    unique case (job.kind) inside
      scmi_pkg::JOB_CONFIG:                            last_idx = 2'd3;
      scmi_pkg::JOB_EXPOSURE:                          last_idx = 2'd2;
      scmi_pkg::JOB_LED_STATE, scmi_pkg::JOB_ERR_LED:  last_idx = 2'd1;
      default:                                         last_idx = 2'd0;
    endcase
    unique case (job.kind) inside
      scmi_pkg::JOB_ERR, scmi_pkg::JOB_ERR_LED: status = scmi_pkg::ST_ERR;
      scmi_pkg::JOB_INVALID:                    status = scmi_pkg::ST_INVALID;
      default:                                  status = scmi_pkg::ST_OK;
    endcase
  end

  always_comb begin
    case (idx)
      2'd0:    cur.reply_byte = status;
      2'd1:    cur.reply_byte = (job.kind == scmi_pkg::JOB_ERR_LED) ?
                                scmi_pkg::LED_ERR_FILL : job.a;
      2'd2:    cur.reply_byte = job.b;
      default: cur.reply_byte = job.c;
    endcase
    cur.reply_last     = (idx == last_idx);
    cur.program_strobe = (job.kind == scmi_pkg::JOB_OK_PROGRAM);
    // Rows repeat over five columns; gain and binning fill the low bits.
    cur.program_word   = cur.program_strobe ?
                         {{5{job.c[4:0]}}, scmi_pkg::gain_bits(job.b), job.a[0]} : 28'd0;
    cur.capture_start  = (job.kind == scmi_pkg::JOB_OK_CAPTURE);
    cur.led0_state     = job.led0;
    cur.led1_state     = job.led1;
    cur.exposure_out   = job.exposure;
  end

  assign load    = !job_empty && (!out_valid || pop);
  assign job_pop = load && cur.reply_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= cur.reply_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= cur;
  end

endmodule

// ===== hw/rtl/sensor_command_interpreter.sv =====
// Top level of the sensor command interpreter: front parser, job queue, reply back end.
//
// Host words enter through push/full, one command key or payload byte each.
// A word is taken in every cycle while the job queue (QUEUE_DEPTH jobs) has
// room; full rises only when the queue is full. The front end updates the
// LED, array configuration and exposure state at once and queues one job per
// word that causes a reply. The back end sends one reply word per cycle while
// the receiver keeps pop high, and a job has one to four reply words there (get
// config four, get exposure three, get LED two, everything else one); that byte
// sequencer sets the sustained rate. The first reply word of a job passes through
// the job queue and the back end's output register before it reaches the result
// ports, or later when earlier replies are still waiting. Each reply word
// carries the LED and exposure values as they stood after its command, and
// program_strobe/program_word or capture_start on the ok word of a valid
// array configuration or a capture. reply_last marks the final word of each
// reply. Reset is synchronous and brings the state to both LEDs off,
// binning off, gain 1x, all rows on and an exposure of fifty ticks.
module sensor_command_interpreter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  reply_byte,
  output logic        reply_last,
  output logic        program_strobe,
  output logic [27:0] program_word,
  output logic        capture_start,
  output logic [1:0]  led0_state,
  output logic [1:0]  led1_state,
  output logic [15:0] exposure_out
);

  logic              accept;
  logic              job_push;
  logic              job_pop;
  logic              job_empty;
  scmi_pkg::job_t    front_job;
  scmi_pkg::job_t    head_job;
  scmi_pkg::result_t result;

  // Accept a word only while the queue can take any job it may cause.
  assign accept = push && !full;

  scmi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .job_push (job_push),
    .job      (front_job)
  );

  scmi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .full     (full),
    .pop      (job_pop),
    .pop_job  (head_job),
    .empty    (job_empty)
  );

  scmi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  // Drive the result ports from the back end's output register.
  assign reply_byte     = result.reply_byte;
  assign reply_last     = result.reply_last;
  assign program_strobe = result.program_strobe;
  assign program_word   = result.program_word;
  assign capture_start  = result.capture_start;
  assign led0_state     = result.led0_state;
  assign led1_state     = result.led1_state;
  assign exposure_out   = result.exposure_out;

`ifndef SYNTH
  // A taken word that is not the last of its reply is followed at once by the next.
  a_reply_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !reply_last) |=> !empty)
    else $error("reply run broken before its last word");

  // A programming strobe comes only on a single ok word.
  a_strobe_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && program_strobe) |-> (reply_last && reply_byte == scmi_pkg::ST_OK))
    else $error("program strobe on a word other than a final ok");

  // The programming word is zero unless strobed.
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !program_strobe) |-> (program_word == 28'd0))
    else $error("program word set without strobe");

  // Capture start comes on the ok word only.
  a_capture_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && capture_start) |-> (reply_last && reply_byte == scmi_pkg::ST_OK))
    else $error("capture start on a word other than a final ok");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the sensor command interpreter: host byte stream in, reply words out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Parser position inside a command: waiting for a key, or for payload byte 1, 2 or 3.
  typedef enum logic [1:0] {
    WAIT_KEY    = 2'd0,
    WANT_FIRST  = 2'd1,
    WANT_SECOND = 2'd2,
    WANT_THIRD  = 2'd3
  } parse_pos_t;

  localparam int RANDOM_BYTES = 120;
  localparam int HOLD_START   = 60;    // receiver cycle at which the long hold-off begins
  localparam int HOLD_LEN     = 80;    // long enough to fill the job queue and stall push
  localparam int DRAIN_CYCLES = 12;    // drain time spent watching for stray reply words

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  reply_byte;
  logic        reply_last;
  logic        program_strobe;
  logic [27:0] program_word;
  logic        capture_start;
  logic [1:0]  led0_state;
  logic [1:0]  led1_state;
  logic [15:0] exposure_out;

  sensor_command_interpreter u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .rx_byte        (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .reply_byte     (reply_byte),
    .reply_last     (reply_last),
    .program_strobe (program_strobe),
    .program_word   (program_word),
    .capture_start  (capture_start),
    .led0_state     (led0_state),
    .led1_state     (led1_state),
    .exposure_out   (exposure_out)
  );

  always #5 clk = ~clk;

  // Host bytes not yet taken by the block, oldest first.
  logic [7:0] host_bytes[$];
  // Reply words the block owes, oldest first.
  scmi_pkg::result_t reply_words[$];
  int         error_count = 0;
  logic       took_host = 1'b0;

  // Mirror of the block's state.
  parse_pos_t  parse_pos = WAIT_KEY;
  logic [7:0]  open_cmd = scmi_pkg::KEY_NULL;
  logic [7:0]  held_a = 8'h00;
  logic [7:0]  held_b = 8'h00;
  logic [1:0]  led_mirror[2] = '{2'd0, 2'd0};
  logic [7:0]  cfg_binning = 8'h00;
  logic [7:0]  cfg_gain = scmi_pkg::GAIN_1X;
  logic [7:0]  cfg_rows = scmi_pkg::ROWS_ALL;
  logic [15:0] exposure_mirror = scmi_pkg::EXPOSURE_RESET;

  // Print one mismatch line and count it.
  task automatic flag_reply_error(input string what, input longint unsigned got,
                                  input longint unsigned want);
    $display("%0t ns: reply %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Advance the mirror by one host byte and queue the reply words it causes.
  task automatic decode_host_byte(input logic [7:0] b);
    logic [7:0]  out_bytes[4];
    int          n;
    logic        strobe;
    logic        cap;
    logic [27:0] word;
    logic [1:0]  gain_field;
    scmi_pkg::result_t r;
    n = 0;
    strobe = 1'b0;
    cap = 1'b0;
    word = '0;
    case (parse_pos)
      WAIT_KEY: begin
        case (b)
          scmi_pkg::KEY_NULL: ;
          scmi_pkg::KEY_GET_LED, scmi_pkg::KEY_SET_LED, scmi_pkg::KEY_SET_CONFIG,
          scmi_pkg::KEY_SET_EXPOSURE: begin
            open_cmd = b;
            parse_pos = WANT_FIRST;
          end
          scmi_pkg::KEY_GET_CONFIG: begin
            out_bytes[0] = scmi_pkg::ST_OK;
            out_bytes[1] = cfg_binning;
            out_bytes[2] = cfg_gain;
            out_bytes[3] = cfg_rows;
            n = 4;
          end
          scmi_pkg::KEY_GET_EXPOSURE: begin
            out_bytes[0] = scmi_pkg::ST_OK;
            out_bytes[1] = exposure_mirror[15:8];
            out_bytes[2] = exposure_mirror[7:0];
            n = 3;
          end
          scmi_pkg::KEY_CAPTURE: begin
            out_bytes[0] = scmi_pkg::ST_OK;
            cap = 1'b1;
            n = 1;
          end
          default: begin
            out_bytes[0] = scmi_pkg::ST_INVALID;
            n = 1;
          end
        endcase
      end
      WANT_FIRST: begin
        if (open_cmd == scmi_pkg::KEY_GET_LED) begin
          parse_pos = WAIT_KEY;
          if (b > 8'd1) begin
            out_bytes[0] = scmi_pkg::ST_ERR;
            out_bytes[1] = scmi_pkg::LED_ERR_FILL;
          end else begin
            out_bytes[0] = scmi_pkg::ST_OK;
            out_bytes[1] = {6'd0, led_mirror[b[0]]};
          end
          n = 2;
        end else begin
          held_a = b;
          parse_pos = WANT_SECOND;
        end
      end
      WANT_SECOND: begin
        if (open_cmd == scmi_pkg::KEY_SET_LED) begin
          parse_pos = WAIT_KEY;
          if (held_a > 8'd1 || b > 8'd2) begin
            out_bytes[0] = scmi_pkg::ST_ERR;
          end else begin
            led_mirror[held_a[0]] = b[1:0];
            out_bytes[0] = scmi_pkg::ST_OK;
          end
          n = 1;
        end else if (open_cmd == scmi_pkg::KEY_SET_EXPOSURE) begin
          parse_pos = WAIT_KEY;
          exposure_mirror = {held_a, b};
          out_bytes[0] = scmi_pkg::ST_OK;
          n = 1;
        end else begin
          held_b = b;
          parse_pos = WANT_THIRD;
        end
      end
      default: begin
        // Third payload byte closes a set config; store all three bytes whatever they hold.
        parse_pos = WAIT_KEY;
        cfg_binning = held_a;
        cfg_gain = held_b;
        cfg_rows = b;
        if ((cfg_binning == 8'h00 || cfg_binning == 8'h01) &&
            (cfg_gain == scmi_pkg::GAIN_1X || cfg_gain == scmi_pkg::GAIN_CODE_A ||
             cfg_gain == scmi_pkg::GAIN_CODE_B || cfg_gain == scmi_pkg::GAIN_CODE_C) &&
            ((cfg_rows & scmi_pkg::ROWS_BAD_MASK) == 8'h00)) begin
          // Gain goes to bits 1-2, the five row enables repeat five times above them.
          case (cfg_gain)
            scmi_pkg::GAIN_CODE_A: gain_field = 2'b10;
            scmi_pkg::GAIN_CODE_B: gain_field = 2'b01;
            scmi_pkg::GAIN_CODE_C: gain_field = 2'b11;
            default:               gain_field = 2'b00;
          endcase
          word = {{5{cfg_rows[4:0]}}, gain_field, cfg_binning[0]};
          strobe = 1'b1;
          out_bytes[0] = scmi_pkg::ST_OK;
        end else begin
          out_bytes[0] = scmi_pkg::ST_ERR;
        end
        n = 1;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      r.reply_byte     = out_bytes[k];
      r.reply_last     = (k == n - 1);
      r.program_strobe = strobe && (k == 0);
      r.program_word   = (k == 0) ? word : 28'd0;
      r.capture_start  = cap && (k == 0);
      r.led0_state     = led_mirror[0];
      r.led1_state     = led_mirror[1];
      r.exposure_out   = exposure_mirror;
      reply_words.push_back(r);
    end
  endtask

  // Monitor: sample both handshakes at the rising edge; predict before checking.
  always @(posedge clk) begin
    scmi_pkg::result_t want;
    took_host <= push && !full && !rst;
    if (!rst && push && !full)
      decode_host_byte(rx_byte);
    if (!rst && pop && !empty) begin
      if (reply_words.size() == 0) begin
        flag_reply_error("word with none owed, byte", reply_byte, 0);
      end else begin
        want = reply_words.pop_front();
        if (reply_byte !== want.reply_byte)
          flag_reply_error("reply_byte", reply_byte, want.reply_byte);
        if (reply_last !== want.reply_last)
          flag_reply_error("reply_last", reply_last, want.reply_last);
        if (program_strobe !== want.program_strobe)
          flag_reply_error("program_strobe", program_strobe, want.program_strobe);
        if (program_word !== want.program_word)
          flag_reply_error("program_word", program_word, want.program_word);
        if (capture_start !== want.capture_start)
          flag_reply_error("capture_start", capture_start, want.capture_start);
        if (led0_state !== want.led0_state)
          flag_reply_error("led0_state", led0_state, want.led0_state);
        if (led1_state !== want.led1_state)
          flag_reply_error("led1_state", led1_state, want.led1_state);
        if (exposure_out !== want.exposure_out)
          flag_reply_error("exposure_out", exposure_out, want.exposure_out);
      end
    end
  end

  // Driver: offer host bytes in bursts of random length with random gaps between them.
  // A gap only opens after a word has been taken, so an offered byte is held until accepted.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (took_host) begin
      void'(host_bytes.pop_front());
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        // Leave about a third of the bursts back to back, with no gap at all.
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
    if (rst || host_bytes.size() == 0 || gap_left != 0) begin
      if (!rst && gap_left != 0)
        gap_left--;
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      rx_byte <= host_bytes[0];
    end
  end

  // Receiver: switch between stall modes at random, and once hold
  // pop low for a long stretch so the job queue fills and full stalls the host side.
  int sink_cycle = 0;
  int sink_mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin
    sink_cycle++;
    if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_LEN) begin
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 40);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        0:       pop <= 1'b1;
        1:       pop <= $urandom_range(0, 1);
        2:       pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  // Stimulus and end of run.
  initial begin
    int directed_len;
    int null_count;
    int kind;
    logic [7:0] led_num;
    logic [7:0] led_val;
    // Directed opening: every key, the LED error paths, a valid and an invalid
    // array setting, and the largest exposure.
    host_bytes = {scmi_pkg::KEY_NULL, scmi_pkg::KEY_GET_CONFIG, scmi_pkg::KEY_GET_EXPOSURE,
                  scmi_pkg::KEY_CAPTURE, 8'hFF,
                  scmi_pkg::KEY_GET_LED, 8'h00,
                  scmi_pkg::KEY_GET_LED, 8'h02,
                  scmi_pkg::KEY_SET_LED, 8'h01, 8'h02,
                  scmi_pkg::KEY_SET_LED, 8'h02, 8'h03,
                  scmi_pkg::KEY_SET_CONFIG, 8'h01, scmi_pkg::GAIN_CODE_C, scmi_pkg::ROWS_ALL,
                  scmi_pkg::KEY_SET_CONFIG, 8'h02, scmi_pkg::GAIN_CODE_A,
                  scmi_pkg::ROWS_BAD_MASK,
                  scmi_pkg::KEY_SET_EXPOSURE, 8'hFF, 8'hFF};
    directed_len = host_bytes.size();
    null_count = 0;
    // Random part: mostly well-formed commands with random payload, some bad payload,
    // stray bytes and unknown keys. Null keys do not count toward the total.
    while (host_bytes.size() - directed_len - null_count < RANDOM_BYTES) begin
      kind = $urandom_range(0, 15);
      case (kind)
        0: begin
          host_bytes.push_back(scmi_pkg::KEY_NULL);
          null_count++;
        end
        1, 2: begin
          led_num = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 1));
          host_bytes.push_back(scmi_pkg::KEY_GET_LED);
          host_bytes.push_back(led_num);
        end
        3, 4, 5: begin
          led_num = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 1));
          led_val = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 2));
          host_bytes.push_back(scmi_pkg::KEY_SET_LED);
          host_bytes.push_back(led_num);
          host_bytes.push_back(led_val);
        end
        6: host_bytes.push_back(scmi_pkg::KEY_GET_CONFIG);
        7, 8, 9, 10: begin
          host_bytes.push_back(scmi_pkg::KEY_SET_CONFIG);
          if ($urandom_range(0, 4) < 3) begin
            host_bytes.push_back(8'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
              0:       host_bytes.push_back(scmi_pkg::GAIN_1X);
              1:       host_bytes.push_back(scmi_pkg::GAIN_CODE_A);
              2:       host_bytes.push_back(scmi_pkg::GAIN_CODE_B);
              default: host_bytes.push_back(scmi_pkg::GAIN_CODE_C);
            endcase
            host_bytes.push_back(8'($urandom_range(0, 31)));
          end else begin
            host_bytes.push_back(8'($urandom_range(0, 255)));
            host_bytes.push_back(8'($urandom_range(0, 255)));
            host_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        11: host_bytes.push_back(scmi_pkg::KEY_GET_EXPOSURE);
        12: begin
          host_bytes.push_back(scmi_pkg::KEY_SET_EXPOSURE);
          host_bytes.push_back(8'($urandom_range(0, 255)));
          host_bytes.push_back(8'($urandom_range(0, 255)));
        end
        13: host_bytes.push_back(scmi_pkg::KEY_CAPTURE);
        14: host_bytes.push_back(8'($urandom_range(12, 255)));
        default: host_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: wait for every byte to be taken and every reply word to arrive,
    // then watch a little longer for stray words.
    while (host_bytes.size() != 0 || reply_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
